FILE: src/pger2d_pkg.sv
// ----------------------------------------------------------------------------
// pger2d_pkg
// Types, constants and fixed-point helpers for the SE(2) edge residual block.
// ----------------------------------------------------------------------------
package pger2d_pkg;

   typedef logic signed [47:0] q48_type;
   typedef q48_type vec3_type [3];

   // partial products of two 48-bit magnitudes, split at bit 24
   typedef struct packed {
      logic [47:0] ll;
      logic [47:0] lh;
      logic [47:0] hl;
      logic [47:0] hh;
      logic        neg;
   } qpart_type;

   // Hessian row selector: blocks (a,b) and row j inside the block
   typedef struct packed {
      logic       a;
      logic       b;
      logic [1:0] j;
   } hrow_type;

   localparam int REQ_W  = 288;
   localparam int RSP_W  = 192;
   localparam int KIND_W = 4;
   localparam int CSR_AW = 3;

   localparam logic [KIND_W-1:0] ROW_ERR   = 4'd0;
   localparam logic [KIND_W-1:0] ROW_WERR  = 4'd1;
   localparam logic [KIND_W-1:0] ROW_GRAD0 = 4'd2;
   localparam logic [KIND_W-1:0] ROW_GRAD1 = 4'd3;
   localparam logic [KIND_W-1:0] ROW_LAST  = 4'd15;

   localparam logic [CSR_AW-1:0] CSR_INFO_XX = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_INFO_YY = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_INFO_TT = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_INFO_XY = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_INFO_XT = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_INFO_YT = 3'd5;

   localparam logic signed [20:0] Q_PI     = 21'sd205887;
   localparam logic signed [20:0] Q_TWO_PI = 21'sd411775;
   localparam logic signed [31:0] Q_ONE    = 32'sd65536;
   localparam q48_type MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam q48_type MIN48 = 48'sh8000_0000_0000;

   function automatic q48_type sat48(logic signed [49:0] v);
      q48_type r;
      if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
         r = v[47:0];
      end else if (v[49]) begin
         r = MIN48;
      end else begin
         r = MAX48;
      end
      return r;
   endfunction

   function automatic q48_type add2(q48_type a, q48_type b);
      return sat48(50'(a) + 50'(b));
   endfunction

   function automatic q48_type sub2(q48_type a, q48_type b);
      return sat48(50'(a) - 50'(b));
   endfunction

   function automatic q48_type add3(q48_type a, q48_type b, q48_type c);
      return sat48(50'(a) + 50'(b) + 50'(c));
   endfunction

   function automatic q48_type neg48(q48_type a);
      return sat48(-50'(a));
   endfunction

   function automatic qpart_type qmul_part(q48_type a, q48_type b);
      logic [47:0] ua;
      logic [47:0] ub;
      qpart_type   p;
      ua = a[47] ? 48'(-a) : 48'(a);
      ub = b[47] ? 48'(-b) : 48'(b);
      p.ll  = ua[23:0] * ub[23:0];
      p.lh  = ua[23:0] * ub[47:24];
      p.hl  = ua[47:24] * ub[23:0];
      p.hh  = ua[47:24] * ub[47:24];
      p.neg = a[47] ^ b[47];
      return p;
   endfunction

   // combine, round half away from zero, drop 16 fraction bits, saturate
   function automatic q48_type qmul_fin(qpart_type p);
      logic [96:0] full;
      logic [80:0] r;
      q48_type     q;
      full = 97'({p.hh, 48'd0}) + (97'(p.lh) << 24) + (97'(p.hl) << 24)
           + 97'(p.ll) + 97'(16'h8000);
      r = full[96:16];
      if (p.neg) begin
         q = (r[80:47] != '0) ? MIN48 : -$signed(r[47:0]);
      end else begin
         q = (r[80:47] != '0) ? MAX48 : $signed(r[47:0]);
      end
      return q;
   endfunction

   function automatic hrow_type hrow_decode(logic [KIND_W-1:0] kind);
      hrow_type h;
      case (kind)
         4'd4:    h = '{a: 1'b0, b: 1'b0, j: 2'd0};
         4'd5:    h = '{a: 1'b0, b: 1'b0, j: 2'd1};
         4'd6:    h = '{a: 1'b0, b: 1'b0, j: 2'd2};
         4'd7:    h = '{a: 1'b0, b: 1'b1, j: 2'd0};
         4'd8:    h = '{a: 1'b0, b: 1'b1, j: 2'd1};
         4'd9:    h = '{a: 1'b0, b: 1'b1, j: 2'd2};
         4'd10:   h = '{a: 1'b1, b: 1'b0, j: 2'd0};
         4'd11:   h = '{a: 1'b1, b: 1'b0, j: 2'd1};
         4'd12:   h = '{a: 1'b1, b: 1'b0, j: 2'd2};
         4'd13:   h = '{a: 1'b1, b: 1'b1, j: 2'd0};
         4'd14:   h = '{a: 1'b1, b: 1'b1, j: 2'd1};
         4'd15:   h = '{a: 1'b1, b: 1'b1, j: 2'd2};
         default: h = '{a: 1'b0, b: 1'b0, j: 2'd0};
      endcase
      return h;
   endfunction

   // column j of Jacobian blk (ex0 or ex1)
   function automatic vec3_type jac_col(logic blk, logic [1:0] j, q48_type c,
                                        q48_type s, q48_type py, q48_type npx);
      vec3_type v;
      case ({blk, j})
         3'b000:  v = '{-c, s, 48'sd0};
         3'b001:  v = '{-s, -c, 48'sd0};
         3'b010:  v = '{py, npx, -48'(Q_ONE)};
         3'b100:  v = '{c, -s, 48'sd0};
         3'b101:  v = '{s, c, 48'sd0};
         3'b110:  v = '{48'sd0, 48'sd0, 48'(Q_ONE)};
         default: v = '{48'sd0, 48'sd0, 48'sd0};
      endcase
      return v;
   endfunction

endpackage

FILE: src/pose_graph_edge_residual_2d.sv
// ----------------------------------------------------------------------------
// pose_graph_edge_residual_2d
// SE(2) pose-graph edge error, weighted error, cost, gradient and Hessian rows.
// ----------------------------------------------------------------------------
// One edge enters on the req_ stream (both poses, cos/sin of the first
// heading, measured relative pose). For each edge sixteen rows leave on the
// rsp_ stream in row_kind order 0..15, tlast marking kind 15; every row also
// carries the edge cost. The csr_ channel writes the six information matrix
// entries; it is always ready and should be written while no edge is in flight.
// Each row runs through a nine-stage pipeline of three multiply levels (error,
// then I*e and J^T*I, then the final dot products), each level split into
// partial products, combine/round and sum stages. Rows leave at one per cycle
// while rsp_tready is high, set by the single result channel; the next edge
// is accepted in the cycle its predecessor issues its last row.
// Reset empties the pipeline and loads I with the identity.
// With a row waiting and rsp_tready low the whole pipeline holds; no row is
// lost or repeated. req_tready drops once the held edge has rows left to issue.
// ----------------------------------------------------------------------------
module pose_graph_edge_residual_2d (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // from_x, from_y, from_heading, from_cos, from_sin, to_x, to_y,
   // to_heading, meas_x, meas_y, meas_heading, zero pad
   input  logic [pger2d_pkg::REQ_W-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // val0, val1, val2, cost
   output logic [pger2d_pkg::RSP_W-1:0]     rsp_tdata,
   // row_kind
   output logic [pger2d_pkg::KIND_W-1:0]    rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pger2d_pkg::CSR_AW-1:0]    csr_index,
   input  logic [31:0]                      csr_data
);

   // configuration
   logic signed [31:0] info_xx_ff, info_yy_ff, info_tt_ff;
   logic signed [31:0] info_xy_ff, info_xt_ff, info_yt_ff;
   pger2d_pkg::q48_type im [3][3];

   // issue stage
   logic [pger2d_pkg::REQ_W-1:0]  item_ff;
   logic                          item_v_ff;
   logic [pger2d_pkg::KIND_W-1:0] cnt_ff;
   logic en, issue, req_acc;

   // stage 1
   logic                          v1_ff;
   logic [pger2d_pkg::KIND_W-1:0] k1_ff;
   pger2d_pkg::q48_type           c1_ff, s1_ff, mx1_ff, my1_ff, et1_ff;
   pger2d_pkg::qpart_type         p1_ff [4];
   pger2d_pkg::q48_type           c1_in, s1_in, mx1_in, my1_in, et1_in;
   pger2d_pkg::qpart_type         p1_in [4];
   // stage 2
   logic                          v2_ff;
   logic [pger2d_pkg::KIND_W-1:0] k2_ff;
   pger2d_pkg::q48_type           c2_ff, s2_ff, mx2_ff, my2_ff, et2_ff;
   pger2d_pkg::q48_type           q2_ff [4];
   // stage 3
   logic                          v3_ff;
   logic [pger2d_pkg::KIND_W-1:0] k3_ff;
   pger2d_pkg::q48_type           c3_ff, s3_ff, px3_ff, py3_ff;
   pger2d_pkg::vec3_type          e3_ff;
   pger2d_pkg::q48_type           px3_in, py3_in;
   pger2d_pkg::vec3_type          e3_in;
   // stage 4
   logic                          v4_ff;
   logic [pger2d_pkg::KIND_W-1:0] k4_ff;
   pger2d_pkg::q48_type           c4_ff, s4_ff, py4_ff, npx4_ff;
   pger2d_pkg::vec3_type          e4_ff;
   pger2d_pkg::qpart_type         pd4_ff [9];
   pger2d_pkg::qpart_type         pt4_ff [9];
   pger2d_pkg::qpart_type         pd4_in [9];
   pger2d_pkg::qpart_type         pt4_in [9];
   // stage 5
   logic                          v5_ff;
   logic [pger2d_pkg::KIND_W-1:0] k5_ff;
   pger2d_pkg::q48_type           c5_ff, s5_ff, py5_ff, npx5_ff;
   pger2d_pkg::vec3_type          e5_ff;
   pger2d_pkg::q48_type           qd5_ff [9];
   pger2d_pkg::q48_type           qt5_ff [9];
   // stage 6
   logic                          v6_ff;
   logic [pger2d_pkg::KIND_W-1:0] k6_ff;
   pger2d_pkg::q48_type           c6_ff, s6_ff, py6_ff, npx6_ff;
   pger2d_pkg::vec3_type          e6_ff, d6_ff, t6_ff;
   pger2d_pkg::vec3_type          d6_in, t6_in;
   // stage 7
   logic                          v7_ff;
   logic [pger2d_pkg::KIND_W-1:0] k7_ff;
   pger2d_pkg::vec3_type          e7_ff, d7_ff;
   pger2d_pkg::qpart_type         p7_ff [12];
   pger2d_pkg::qpart_type         p7_in [12];
   // stage 8
   logic                          v8_ff;
   logic [pger2d_pkg::KIND_W-1:0] k8_ff;
   pger2d_pkg::vec3_type          e8_ff, d8_ff;
   pger2d_pkg::q48_type           q8_ff [12];
   // output
   logic                          out_v_ff;
   logic [pger2d_pkg::KIND_W-1:0] out_k_ff;
   logic [pger2d_pkg::RSP_W-1:0]  out_d_ff;
   logic [pger2d_pkg::RSP_W-1:0]  out_d_in;

   assign csr_ready  = 1'b1;
   assign en         = !out_v_ff || rsp_tready;
   assign issue      = item_v_ff && en;
   assign req_tready = !item_v_ff || (en && cnt_ff == pger2d_pkg::ROW_LAST);
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_k_ff;
   assign rsp_tlast  = (out_k_ff == pger2d_pkg::ROW_LAST);

   always_comb begin
      im[0][0] = 48'(info_xx_ff); im[0][1] = 48'(info_xy_ff); im[0][2] = 48'(info_xt_ff);
      im[1][0] = 48'(info_xy_ff); im[1][1] = 48'(info_yy_ff); im[1][2] = 48'(info_yt_ff);
      im[2][0] = 48'(info_xt_ff); im[2][1] = 48'(info_yt_ff); im[2][2] = 48'(info_tt_ff);
   end

   // stage 1: differences, heading wrap, level-one partial products
   always_comb begin
      logic signed [32:0] dx, dy;
      logic signed [20:0] et;
      pger2d_pkg::q48_type dx48, dy48;
      dx = 33'($signed(item_ff[150:119])) - 33'($signed(item_ff[31:0]));
      dy = 33'($signed(item_ff[182:151])) - 33'($signed(item_ff[63:32]));
      et = 21'($signed(item_ff[201:183])) - 21'($signed(item_ff[82:64]))
         - 21'($signed(item_ff[284:266]));
      if (et > pger2d_pkg::Q_PI) begin
         et = et - pger2d_pkg::Q_TWO_PI;
         if (et > pger2d_pkg::Q_PI) begin
            et = et - pger2d_pkg::Q_TWO_PI;
         end
      end else if (et < -pger2d_pkg::Q_PI) begin
         et = et + pger2d_pkg::Q_TWO_PI;
         if (et < -pger2d_pkg::Q_PI) begin
            et = et + pger2d_pkg::Q_TWO_PI;
         end
      end
      dx48   = 48'(dx);
      dy48   = 48'(dy);
      c1_in  = 48'($signed(item_ff[100:83]));
      s1_in  = 48'($signed(item_ff[118:101]));
      mx1_in = 48'($signed(item_ff[233:202]));
      my1_in = 48'($signed(item_ff[265:234]));
      et1_in = 48'(et);
      p1_in[0] = pger2d_pkg::qmul_part(c1_in, dx48);
      p1_in[1] = pger2d_pkg::qmul_part(s1_in, dy48);
      p1_in[2] = pger2d_pkg::qmul_part(-s1_in, dx48);
      p1_in[3] = pger2d_pkg::qmul_part(c1_in, dy48);
   end

   // stage 3: rotated difference and error vector
   always_comb begin
      px3_in   = pger2d_pkg::add2(q2_ff[0], q2_ff[1]);
      py3_in   = pger2d_pkg::add2(q2_ff[2], q2_ff[3]);
      e3_in[0] = pger2d_pkg::sub2(px3_in, mx2_ff);
      e3_in[1] = pger2d_pkg::sub2(py3_in, my2_ff);
      e3_in[2] = et2_ff;
   end

   // stage 4: partials of d = I e and of one row of ex_a^T I
   always_comb begin
      pger2d_pkg::hrow_type h;
      pger2d_pkg::vec3_type col;
      h   = pger2d_pkg::hrow_decode(k3_ff);
      col = pger2d_pkg::jac_col(h.a, h.j, c3_ff, s3_ff, py3_ff,
                                pger2d_pkg::neg48(px3_ff));
      for (int i = 0; i < 3; i++) begin
         for (int m = 0; m < 3; m++) begin
            pd4_in[i*3+m] = pger2d_pkg::qmul_part(im[i][m], e3_ff[m]);
            pt4_in[m*3+i] = pger2d_pkg::qmul_part(col[i], im[i][m]);
         end
      end
   end

   // stage 6: sum into d and the Hessian intermediate row
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d6_in[i] = pger2d_pkg::add3(qd5_ff[i*3], qd5_ff[i*3+1], qd5_ff[i*3+2]);
         t6_in[i] = pger2d_pkg::add3(qt5_ff[i*3], qt5_ff[i*3+1], qt5_ff[i*3+2]);
      end
   end

   // stage 7: partials of the row elements and the cost
   always_comb begin
      pger2d_pkg::hrow_type h;
      pger2d_pkg::vec3_type lv, rv;
      h = pger2d_pkg::hrow_decode(k6_ff);
      for (int j = 0; j < 3; j++) begin
         if (k6_ff == pger2d_pkg::ROW_GRAD0 || k6_ff == pger2d_pkg::ROW_GRAD1) begin
            lv = pger2d_pkg::jac_col(k6_ff[0], 2'(j), c6_ff, s6_ff, py6_ff, npx6_ff);
            rv = d6_ff;
         end else begin
            lv = t6_ff;
            rv = pger2d_pkg::jac_col(h.b, 2'(j), c6_ff, s6_ff, py6_ff, npx6_ff);
         end
         for (int i = 0; i < 3; i++) begin
            p7_in[j*3+i] = pger2d_pkg::qmul_part(lv[i], rv[i]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         p7_in[9+i] = pger2d_pkg::qmul_part(d6_ff[i], e6_ff[i]);
      end
   end

   // output: final sums and row select
   always_comb begin
      pger2d_pkg::vec3_type r;
      pger2d_pkg::q48_type  cost;
      for (int j = 0; j < 3; j++) begin
         r[j] = pger2d_pkg::add3(q8_ff[j*3], q8_ff[j*3+1], q8_ff[j*3+2]);
      end
      cost = pger2d_pkg::add3(q8_ff[9], q8_ff[10], q8_ff[11]);
      case (k8_ff)
         pger2d_pkg::ROW_ERR:  out_d_in = {cost, e8_ff[2], e8_ff[1], e8_ff[0]};
         pger2d_pkg::ROW_WERR: out_d_in = {cost, d8_ff[2], d8_ff[1], d8_ff[0]};
         default:              out_d_in = {cost, r[2], r[1], r[0]};
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff  <= 1'b0;
         cnt_ff     <= '0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         v5_ff      <= 1'b0;
         v6_ff      <= 1'b0;
         v7_ff      <= 1'b0;
         v8_ff      <= 1'b0;
         out_v_ff   <= 1'b0;
         info_xx_ff <= pger2d_pkg::Q_ONE;
         info_yy_ff <= pger2d_pkg::Q_ONE;
         info_tt_ff <= pger2d_pkg::Q_ONE;
         info_xy_ff <= '0;
         info_xt_ff <= '0;
         info_yt_ff <= '0;
      end else begin
         if (req_acc) begin
            item_v_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (issue) begin
            // drop the edge after its last row
            if (cnt_ff == pger2d_pkg::ROW_LAST) begin
               item_v_ff <= 1'b0;
            end
            cnt_ff <= cnt_ff + 4'd1;
         end
         if (en) begin
            v1_ff    <= issue;
            v2_ff    <= v1_ff;
            v3_ff    <= v2_ff;
            v4_ff    <= v3_ff;
            v5_ff    <= v4_ff;
            v6_ff    <= v5_ff;
            v7_ff    <= v6_ff;
            v8_ff    <= v7_ff;
            out_v_ff <= v8_ff;
         end
         if (csr_valid) begin
            case (csr_index)
               pger2d_pkg::CSR_INFO_XX: info_xx_ff <= csr_data;
               pger2d_pkg::CSR_INFO_YY: info_yy_ff <= csr_data;
               pger2d_pkg::CSR_INFO_TT: info_tt_ff <= csr_data;
               pger2d_pkg::CSR_INFO_XY: info_xy_ff <= csr_data;
               pger2d_pkg::CSR_INFO_XT: info_xt_ff <= csr_data;
               pger2d_pkg::CSR_INFO_YT: info_yt_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         item_ff <= req_tdata;
      end
      if (en) begin
         k1_ff  <= cnt_ff;
         c1_ff  <= c1_in;
         s1_ff  <= s1_in;
         mx1_ff <= mx1_in;
         my1_ff <= my1_in;
         et1_ff <= et1_in;
         for (int i = 0; i < 4; i++) begin
            p1_ff[i] <= p1_in[i];
            q2_ff[i] <= pger2d_pkg::qmul_fin(p1_ff[i]);
         end
         k2_ff  <= k1_ff;
         c2_ff  <= c1_ff;
         s2_ff  <= s1_ff;
         mx2_ff <= mx1_ff;
         my2_ff <= my1_ff;
         et2_ff <= et1_ff;

         k3_ff  <= k2_ff;
         c3_ff  <= c2_ff;
         s3_ff  <= s2_ff;
         px3_ff <= px3_in;
         py3_ff <= py3_in;
         e3_ff  <= e3_in;

         k4_ff   <= k3_ff;
         c4_ff   <= c3_ff;
         s4_ff   <= s3_ff;
         py4_ff  <= py3_ff;
         npx4_ff <= pger2d_pkg::neg48(px3_ff);
         e4_ff   <= e3_ff;
         for (int i = 0; i < 9; i++) begin
            pd4_ff[i] <= pd4_in[i];
            pt4_ff[i] <= pt4_in[i];
            qd5_ff[i] <= pger2d_pkg::qmul_fin(pd4_ff[i]);
            qt5_ff[i] <= pger2d_pkg::qmul_fin(pt4_ff[i]);
         end
         k5_ff   <= k4_ff;
         c5_ff   <= c4_ff;
         s5_ff   <= s4_ff;
         py5_ff  <= py4_ff;
         npx5_ff <= npx4_ff;
         e5_ff   <= e4_ff;

         k6_ff   <= k5_ff;
         c6_ff   <= c5_ff;
         s6_ff   <= s5_ff;
         py6_ff  <= py5_ff;
         npx6_ff <= npx5_ff;
         e6_ff   <= e5_ff;
         d6_ff   <= d6_in;
         t6_ff   <= t6_in;

         k7_ff <= k6_ff;
         e7_ff <= e6_ff;
         d7_ff <= d6_ff;
         for (int i = 0; i < 12; i++) begin
            p7_ff[i] <= p7_in[i];
            q8_ff[i] <= pger2d_pkg::qmul_fin(p7_ff[i]);
         end
         k8_ff <= k7_ff;
         e8_ff <= e7_ff;
         d8_ff <= d7_ff;

         out_k_ff <= k8_ff;
         out_d_ff <= out_d_in;
      end
   end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SE(2) pose-graph edge residual block: edges are
// streamed in, a local fixed-point predictor builds the sixteen rows of every
// edge, and each returned row is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pger2d_pkg::CSR_AW-1:0] CSR_SPARE = 3'd6;
   localparam logic [pger2d_pkg::CSR_AW-1:0] CSR_TOP   = 3'd7;
   localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SAT_LO = -SAT_HI - 1;
   localparam longint PI_Q   = 205887;
   localparam longint TWOPI_Q = 411775;
   localparam longint ONE_Q  = 65536;
   localparam int     CYCLE_LIMIT = 600000;

   typedef struct {
      logic signed [31:0] fx, fy, tx, ty, mx, my;
      logic signed [18:0] fh, th, mh;
      logic signed [17:0] fc, fs;
   } edge_type;

   typedef struct {
      logic [pger2d_pkg::KIND_W-1:0] kind;
      longint v0, v1, v2, cost;
      logic last;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [pger2d_pkg::REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [pger2d_pkg::RSP_W-1:0] rsp_tdata;
   logic [pger2d_pkg::KIND_W-1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pger2d_pkg::CSR_AW-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   pose_graph_edge_residual_2d uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   edge_type pending_edges[$];
   edge_type held_edge;
   row_type  rows_due[$];
   longint   info [3][3];
   int errors = 0;
   int rows_seen = 0;
   int edges_sent = 0;
   int cycles = 0;
   int tx_idle = 0;
   int rx_idle = 0;
   logic rsp_hold = 1'b0;
   logic stall_go = 1'b0;

   // ---------------- predictor ----------------
   function automatic longint clamp48(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Q.16 product, round half away from zero, saturate
   function automatic longint qprod(longint a, longint b);
      logic [127:0] ua, ub, r;
      logic neg;
      neg = (a < 0) != (b < 0);
      ua = 128'(a < 0 ? -a : a);
      ub = 128'(b < 0 ? -b : b);
      r = (ua * ub + 128'h8000) >> 16;
      if (r >= (128'd1 << 47)) return neg ? SAT_LO : SAT_HI;
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint dot(longint a0, longint a1, longint a2,
                                  longint b0, longint b1, longint b2);
      return clamp48(qprod(a0, b0) + qprod(a1, b1) + qprod(a2, b2));
   endfunction

   task automatic predict_rows(edge_type ed);
      longint c, s, dx, dy, px, py, et, cst;
      longint e[3], d[3];
      longint jac[2][3][3];
      longint hm[3][3];
      longint val[16][3];
      row_type r;
      c = ed.fc;
      s = ed.fs;
      dx = longint'(ed.tx) - longint'(ed.fx);
      dy = longint'(ed.ty) - longint'(ed.fy);
      px = clamp48(qprod(c, dx) + qprod(s, dy));
      py = clamp48(qprod(-s, dx) + qprod(c, dy));
      e[0] = clamp48(px - ed.mx);
      e[1] = clamp48(py - ed.my);
      et = longint'(ed.th) - longint'(ed.fh) - longint'(ed.mh);
      while (et > PI_Q) et -= TWOPI_Q;
      while (et < -PI_Q) et += TWOPI_Q;
      e[2] = et;
      for (int i = 0; i < 3; i++)
         d[i] = dot(info[i][0], info[i][1], info[i][2], e[0], e[1], e[2]);
      cst = dot(d[0], d[1], d[2], e[0], e[1], e[2]);
      jac[0] = '{'{-c, -s, py}, '{s, -c, clamp48(-px)}, '{0, 0, -ONE_Q}};
      jac[1] = '{'{c, s, 0}, '{-s, c, 0}, '{0, 0, ONE_Q}};
      for (int j = 0; j < 3; j++) begin
         val[0][j] = e[j];
         val[1][j] = d[j];
         for (int k = 0; k < 2; k++)
            val[2 + k][j] = dot(jac[k][0][j], jac[k][1][j], jac[k][2][j],
                                d[0], d[1], d[2]);
      end
      for (int a = 0; a < 2; a++) begin
         for (int j = 0; j < 3; j++)
            for (int m = 0; m < 3; m++)
               hm[j][m] = dot(jac[a][0][j], jac[a][1][j], jac[a][2][j],
                              info[0][m], info[1][m], info[2][m]);
         for (int b = 0; b < 2; b++)
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 3; k++)
                  val[4 + 3 * (2 * a + b) + j][k] =
                     dot(hm[j][0], hm[j][1], hm[j][2],
                         jac[b][0][k], jac[b][1][k], jac[b][2][k]);
      end
      for (int k = 0; k < 16; k++) begin
         r.kind = k[pger2d_pkg::KIND_W-1:0];
         r.v0 = val[k][0];
         r.v1 = val[k][1];
         r.v2 = val[k][2];
         r.cost = cst;
         r.last = (r.kind == pger2d_pkg::ROW_LAST);
         rows_due.push_back(r);
      end
   endtask

   function automatic logic [pger2d_pkg::REQ_W-1:0] pack_edge(edge_type ed);
      return {3'b000, ed.mh, ed.my, ed.mx, ed.th, ed.ty, ed.tx,
              ed.fs, ed.fc, ed.fh, ed.fy, ed.fx};
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_rows(held_edge);
            edges_sent <= edges_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_edges.size() > 0 && $urandom_range(99) >= tx_idle) begin
               held_edge <= pending_edges[0];
               req_tdata <= pack_edge(pending_edges.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (row %0d)", what, got, want, rows_seen);
      errors++;
   endtask

   always @(posedge clock) begin
      row_type w;
      if (!reset) begin
         rsp_tready <= !rsp_hold && ($urandom_range(99) >= rx_idle);
         if (rsp_tvalid && rsp_tready) begin
            rows_seen <= rows_seen + 1;
            if (rows_due.size() == 0) begin
               report("unexpected row kind", rsp_tuser, -1);
            end else begin
               w = rows_due.pop_front();
               if (rsp_tuser != w.kind) report("row_kind", rsp_tuser, w.kind);
               if ($signed(rsp_tdata[47:0]) != w.v0)
                  report("val0", $signed(rsp_tdata[47:0]), w.v0);
               if ($signed(rsp_tdata[95:48]) != w.v1)
                  report("val1", $signed(rsp_tdata[95:48]), w.v1);
               if ($signed(rsp_tdata[143:96]) != w.v2)
                  report("val2", $signed(rsp_tdata[143:96]), w.v2);
               if ($signed(rsp_tdata[191:144]) != w.cost)
                  report("cost", $signed(rsp_tdata[191:144]), w.cost);
               if (rsp_tlast != w.last) report("last_row", rsp_tlast, w.last);
            end
         end
      end
   end

   // long receiver hold-off so the pipeline backs up into the input
   initial begin
      wait (stall_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d rows outstanding", rows_due.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic write_reg(logic [pger2d_pkg::CSR_AW-1:0] idx, logic signed [31:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         pger2d_pkg::CSR_INFO_XX: info[0][0] = v;
         pger2d_pkg::CSR_INFO_YY: info[1][1] = v;
         pger2d_pkg::CSR_INFO_TT: info[2][2] = v;
         pger2d_pkg::CSR_INFO_XY: begin info[0][1] = v; info[1][0] = v; end
         pger2d_pkg::CSR_INFO_XT: begin info[0][2] = v; info[2][0] = v; end
         pger2d_pkg::CSR_INFO_YT: begin info[1][2] = v; info[2][1] = v; end
         default: ;
      endcase
   endtask

   task automatic load_info(logic signed [31:0] xx, yy, tt, xy, xt, yt);
      write_reg(pger2d_pkg::CSR_INFO_XX, xx);
      write_reg(pger2d_pkg::CSR_INFO_YY, yy);
      write_reg(pger2d_pkg::CSR_INFO_TT, tt);
      write_reg(pger2d_pkg::CSR_INFO_XY, xy);
      write_reg(pger2d_pkg::CSR_INFO_XT, xt);
      write_reg(pger2d_pkg::CSR_INFO_YT, yt);
   endtask

   // sample on the falling edge so driver updates have settled
   task automatic drain();
      do @(negedge clock);
      while (pending_edges.size() != 0 || req_tvalid || rows_due.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rnd_info(int mode);
      case (mode)
         0: return $signed(32'($urandom_range(131072)));
         1: return $signed(32'($urandom_range(65536))) - 32'sd32768;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic edge_type rnd_edge();
      edge_type ed;
      real h;
      int sel;
      sel = $urandom_range(9);
      ed.fx = $signed($urandom());
      ed.fy = $signed($urandom());
      ed.tx = $signed($urandom());
      ed.ty = $signed($urandom());
      ed.mx = $signed($urandom());
      ed.my = $signed($urandom());
      ed.fh = $signed(19'($urandom()));
      ed.th = $signed(19'($urandom()));
      ed.mh = $signed(19'($urandom()));
      ed.fc = $signed(18'($urandom()));
      ed.fs = $signed(18'($urandom()));
      if (sel < 7) begin
         // plausible edge: unit cos/sin pair; modest positions when sel < 5
         ed.fh = $signed(19'($urandom_range(411774))) - 19'sd205887;
         ed.th = $signed(19'($urandom_range(411774))) - 19'sd205887;
         ed.mh = $signed(19'($urandom_range(411774))) - 19'sd205887;
         h = real'(ed.fh) / 65536.0;
         ed.fc = 18'($rtoi($cos(h) * 65536.0));
         ed.fs = 18'($rtoi($sin(h) * 65536.0));
         if (sel < 5) begin
            ed.fx = $signed(32'($urandom_range(8388608))) - 32'sd4194304;
            ed.fy = $signed(32'($urandom_range(8388608))) - 32'sd4194304;
            ed.tx = ed.fx + $signed(32'($urandom_range(1048576))) - 32'sd524288;
            ed.ty = ed.fy + $signed(32'($urandom_range(1048576))) - 32'sd524288;
            ed.mx = $signed(32'($urandom_range(1048576))) - 32'sd524288;
            ed.my = $signed(32'($urandom_range(1048576))) - 32'sd524288;
         end
      end
      return ed;
   endfunction

   task automatic add_edge(logic signed [31:0] fx, fy, tx, ty, mx, my,
                           logic signed [18:0] fh, th, mh,
                           logic signed [17:0] fc, fs);
      edge_type ed;
      ed = '{fx: fx, fy: fy, tx: tx, ty: ty, mx: mx, my: my,
             fh: fh, th: th, mh: mh, fc: fc, fs: fs};
      pending_edges.push_back(ed);
   endtask

   initial begin
      info = '{'{ONE_Q, 0, 0}, '{0, ONE_Q, 0}, '{0, 0, ONE_Q}};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed edges at reset information matrix
      add_edge(0, 0, 0, 0, 0, 0, 0, 0, 0, 65536, 0);
      add_edge(65536, 131072, 196608, 65536, 131072, -65536, 0, 0, 0, 65536, 0);
      add_edge(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
               32'sh7FFFFFFF, 32'sh80000000, 205887, -205887, 205887, 65536, 65536);
      add_edge(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
               32'sh80000000, 32'sh7FFFFFFF, -205887, 205887, -205887, -65536, -65536);
      add_edge(0, 0, 327680, 0, 0, 0, 0, 205887, -205887, 0, 65536);
      add_edge(0, 0, 0, 327680, 0, 0, 102943, 205887, 0, 0, -65536);
      add_edge(100, -200, 300, -400, 5, 6, 0, 205887, 0, -65536, 0);
      add_edge(100, -200, 300, -400, 5, 6, 0, -205887, 0, 46341, 46341);
      add_edge(0, 0, 65536, 65536, 0, 0, 19'sh3FFFF, 19'sh40000, 19'sh3FFFF,
               18'sh1FFFF, 18'sh20000);
      add_edge(0, 0, 65536, 65536, 0, 0, 19'sh40000, 19'sh3FFFF, 19'sh40000,
               18'sh20000, 18'sh1FFFF);
      add_edge(-1, -1, 1, 1, -1, 1, 1, -1, 1, 1, -1);
      add_edge(32'sh40000000, 0, 32'shC0000000, 0, 0, 0, 0, 0, 0, 65536, 0);
      for (int i = 0; i < 6; i++) pending_edges.push_back(rnd_edge());
      drain();

      // extreme information matrices
      load_info(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      write_reg(CSR_SPARE, 32'h12345678);
      write_reg(CSR_TOP, 32'hFFFFFFFF);
      for (int i = 0; i < 4; i++) pending_edges.push_back(rnd_edge());
      add_edge(32'sh7FFFFFFF, 0, 32'sh80000000, 0, 0, 0, 0, 0, 0, 65536, 0);
      drain();
      load_info(32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 32'sh80000000);
      for (int i = 0; i < 4; i++) pending_edges.push_back(rnd_edge());
      drain();

      // random phases under different idling patterns
      for (int ph = 0; ph < 3; ph++) begin
         load_info(rnd_info(ph), rnd_info(ph), rnd_info(ph),
                   rnd_info(1), rnd_info(1), rnd_info(ph));
         tx_idle = (ph == 0) ? 35 : (ph == 1) ? 74 : 0;
         rx_idle = (ph == 0) ? 74 : (ph == 1) ? 35 : 0;
         if (ph == 2) stall_go <= 1'b1;
         for (int i = 0; i < 70; i++) pending_edges.push_back(rnd_edge());
         drain();
      end

      $display("covered %0d edges, %0d rows, information matrix from reset, extremes",
               edges_sent, rows_seen);
      $display("and random settings, with idling on either side and a long output stall");
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
